// ----- sv/lfr_pkg.sv -----
// lfr_pkg: shared constants and types of the LIN frame receiver.
// Used by lin_frame_receiver_core and lfr_checker; depends on nothing.
`default_nettype none

package lfr_pkg;

	// Frame store depth: identifier plus up to eight data bytes.
	localparam int FRAME_BYTES = 9;
	localparam int DATA_BYTES  = 8;
	localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
	localparam int IDX_W       = $clog2(FRAME_BYTES);

	localparam logic [7:0] SYNC_BYTE = 8'h55;

	// Field widths and the packed result word.
	localparam int OP_W    = 2;
	localparam int ID_W    = 8;
	localparam int LEN_W   = 4;
	localparam int DATA_W  = 64;
	localparam int RES_W   = ID_W + LEN_W + DATA_W;
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;
	localparam int TMO_W   = 16;

	// UART event kinds carried in tuser.
	typedef enum logic [OP_W-1:0] {
		OP_BYTE  = 2'd0,
		OP_BREAK = 2'd1,
		OP_ERROR = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef struct packed {
		logic [DATA_W-1:0] frame_data;
		logic [LEN_W-1:0]  payload_len;
		logic [ID_W-1:0]   frame_id;
	} result_t;

endpackage

`default_nettype wire

// ----- sv/lin_frame_receiver_core.sv -----
// lin_frame_receiver_core: LIN deframer fed by UART events, streaming in and out.
// Depends on lfr_pkg for constants, the event codes and the result layout.
//
// Channel   | Dir | Handshake                 | Payload
// s_axis    | in  | s_axis_tvalid/tready      | tdata[7:0] data_byte, tuser[1:0] operation
// m_axis    | out | m_axis_tvalid/tready      | tdata id[7:0] len[11:8] data[75:12]
// cfg       | in  | cfg_valid/cfg_ready       | cfg_data[15:0] timeout_ms
//
// One event is taken per cycle while s_axis_tready is high; the state update and
// frame assembly sit between the state and result registers, and the frame an
// event ends is registered there (in the skid register while that is held). A
// two-entry output (result plus skid register) keeps input flowing while a result
// waits; s_axis_tready drops only when both are full. Reset returns to idle with
// counters and timeout cleared; the frame store is not reset. cfg_ready is always high.
`default_nettype none

module lin_frame_receiver_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
	input  wire logic [lfr_pkg::OP_W-1:0]      s_axis_tuser,  // [1:0] operation
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [7:0] frame_id, [11:8] payload_len, [75:12] frame_data, [79:76] zero
	output logic [lfr_pkg::TDATA_W-1:0]        m_axis_tdata,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lfr_pkg::TMO_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SYNC = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	phase_t                        phase_q, phase_c, phase_n;
	logic [lfr_pkg::CNT_W-1:0]     cnt_q, cnt_n, cnt_eff;
	logic [lfr_pkg::TMO_W-1:0]     sil_q, sil_n, sil_inc;
	logic [lfr_pkg::TMO_W-1:0]     timeout_q;
	logic [7:0]                    store_q [lfr_pkg::FRAME_BYTES];
	logic [7:0]                    view    [lfr_pkg::FRAME_BYTES];

	logic                          accept;
	logic                          wr_byte;
	logic                          flush_try;
	logic                          emit;
	logic                          restart;
	lfr_pkg::op_t                  op;
	lfr_pkg::result_t              res;
	logic [lfr_pkg::LEN_W-1:0]     len;

	logic                          out_valid_q, skid_valid_q;
	lfr_pkg::result_t              out_data_q, skid_data_q;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !skid_valid_q;
	assign cfg_ready     = 1'b1;
	assign op            = lfr_pkg::op_t'(s_axis_tuser);

	// Treat the unused phase code as idle.
	always_comb begin
		unique case (phase_q)
			PH_SYNC: phase_c = PH_SYNC;
			PH_DATA: phase_c = PH_DATA;
			default: phase_c = PH_IDLE;
		endcase
	end

	assign sil_inc = (sil_q == '1) ? sil_q : sil_q + 1'b1;

	// Event decode: whether to store the byte, whether a flush is attempted, and the next phase and counters.
	always_comb begin
		wr_byte   = 1'b0;
		flush_try = 1'b0;
		restart   = 1'b0;
		phase_n   = phase_c;
		cnt_n     = cnt_q;
		sil_n     = sil_q;
		if (accept) begin
			unique case (op)
				lfr_pkg::OP_BYTE: begin
					sil_n = '0;
					if (phase_c == PH_SYNC) begin
						if (s_axis_tdata == lfr_pkg::SYNC_BYTE) begin
							phase_n = PH_DATA;
						end else begin
							restart = 1'b1;
						end
					end else if (phase_c == PH_DATA) begin
						if (cnt_q < lfr_pkg::CNT_W'(lfr_pkg::FRAME_BYTES)) begin
							wr_byte = 1'b1;
							cnt_n   = cnt_q + 1'b1;
						end
						if (cnt_n >= lfr_pkg::CNT_W'(lfr_pkg::FRAME_BYTES)) begin
							flush_try = 1'b1;
						end
					end
				end
				lfr_pkg::OP_BREAK,
				lfr_pkg::OP_ERROR: begin
					flush_try = 1'b1;
					restart   = 1'b1;
				end
				default: begin
					sil_n = sil_inc;
					if (timeout_q != '0 && phase_c != PH_IDLE && sil_inc >= timeout_q) begin
						flush_try = 1'b1;
					end
				end
			endcase
		end
		cnt_eff = wr_byte ? cnt_q + 1'b1 : cnt_q;
		emit    = flush_try && (phase_c == PH_DATA) && (cnt_eff != '0);
		// Drop back to idle after an emission, a bad sync or an error; a break goes to sync instead.
		if (emit || restart) begin
			cnt_n   = '0;
			sil_n   = '0;
			phase_n = (accept && op == lfr_pkg::OP_BREAK) ? PH_SYNC : PH_IDLE;
		end
	end

	// Store contents as seen after this event's byte lands.
	always_comb begin
		for (int k = 0; k < lfr_pkg::FRAME_BYTES; k++) begin
			view[k] = (wr_byte && cnt_q == lfr_pkg::CNT_W'(k)) ? s_axis_tdata : store_q[k];
		end
	end

	// Assemble the frame; data bytes past the length read as zero.
	always_comb begin
		len               = lfr_pkg::LEN_W'(cnt_eff - 1'b1);
		res.frame_id      = view[0];
		res.payload_len   = len;
		res.frame_data    = '0;
		for (int i = 0; i < lfr_pkg::DATA_BYTES; i++) begin
			if (i + 1 < lfr_pkg::FRAME_BYTES) begin
				if (lfr_pkg::LEN_W'(i) < len) begin
					res.frame_data[8*i +: 8] = view[i + 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			sil_q     <= '0;
			timeout_q <= '0;
		end else begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			sil_q   <= sil_n;
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_byte) begin
			store_q[cnt_q[lfr_pkg::IDX_W-1:0]] <= s_axis_tdata;
		end
	end

	// Output register with a skid stage behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q  <= skid_valid_q || emit;
			skid_valid_q <= 1'b0;
		end else if (emit) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			out_data_q <= skid_valid_q ? skid_data_q : res;
		end else if (emit) begin
			skid_data_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = lfr_pkg::TDATA_W'(out_data_q);

endmodule

`default_nettype wire

// ----- sv/lfr_checker.sv -----
// lfr_checker: port-level assertions for lin_frame_receiver_core, bound to it below.
// Depends on lfr_pkg for widths and the result layout.
`default_nettype none

module lfr_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_axis_tready,
	input wire logic                       m_axis_tvalid,
	input wire logic                       m_axis_tready,
	input wire logic [lfr_pkg::TDATA_W-1:0] m_axis_tdata
);

	lfr_pkg::result_t r;
	assign r = lfr_pkg::result_t'(m_axis_tdata[lfr_pkg::RES_W-1:0]);

	// Hold a stalled result.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> r.payload_len <= lfr_pkg::LEN_W'(lfr_pkg::DATA_BYTES))
		else $error("data length beyond eight");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.payload_len == '0 |-> r.frame_data == '0)
		else $error("frame without data bytes carries data");

	// Input stalls only after the output side has stalled.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output back-pressure");

endmodule

bind lin_frame_receiver_core lfr_checker u_lfr_checker (.*);

`default_nettype wire
